@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("%m");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

@@ design/m3inv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package m3inv_pkg;
  localparam int ElementBits  = 16;
  localparam int FractionBits = 16;
  localparam int InBits       = 16;
  localparam int ProdBits     = 2 * ElementBits;
  localparam int CofBits      = ProdBits + 1;
  localparam int DetBits      = 49;
  localparam int InvBits      = 48;
  localparam int NumBits      = CofBits + FractionBits;
  localparam int QBits        = NumBits;
  localparam int QueueDepth   = 2;

  typedef logic signed [ElementBits-1:0] elem_t;
  typedef logic signed [CofBits-1:0] cof_t;
  typedef logic signed [DetBits-1:0] det_t;

  // Matrix handed from the loader to the solver.
  typedef struct packed {
    elem_t [8:0] m;
  } mat_t;
endpackage
`default_nettype wire

@@ design/m3inv_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Collect nine elements, then push the full matrix into a two-deep queue.
module m3inv_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic [m3inv_pkg::InBits-1:0] in_element_value,
  output logic                      q_valid,
  output m3inv_pkg::mat_t           q_mat,
  input  wire logic                 q_take
);
  m3inv_pkg::mat_t  load_r, load_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  m3inv_pkg::mat_t  qd_r [m3inv_pkg::QueueDepth];
  logic             wp_r, rp_r;
  logic [1:0]       qc_r;
  logic             acc, done;

  assign in_full = (cnt_r == 4'd8) && (qc_r == 2'd2);
  assign acc     = in_push && !in_full;
  assign done    = acc && (cnt_r == 4'd8);
  assign q_valid = (qc_r != 2'd0);
  assign q_mat   = qd_r[rp_r];

  // Store the element and advance the count.
  always_comb begin
    load_nxt = load_r;
    cnt_nxt  = cnt_r;
    if (acc) begin
      load_nxt.m[cnt_r] = in_element_value[m3inv_pkg::ElementBits-1:0];
      cnt_nxt = done ? 4'd0 : cnt_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    load_r <= load_nxt;
    if (!rst_n) begin
      cnt_r <= 4'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      qc_r  <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (done) begin
        qd_r[wp_r] <= load_nxt;
        wp_r <= ~wp_r;
      end
      if (q_take) rp_r <= ~rp_r;
      qc_r <= qc_r + {1'b0, done} - {1'b0, q_take};
    end
  end
endmodule
`default_nettype wire

@@ design/m3inv_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider on magnitudes, one quotient bit per cycle.
module m3inv_divider (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic signed [m3inv_pkg::NumBits-1:0] num,
  input  wire logic signed [m3inv_pkg::DetBits-1:0] den,
  output logic      busy,
  output logic      done,
  output logic signed [m3inv_pkg::QBits-1:0] quo
);
  localparam int NB = m3inv_pkg::NumBits;
  localparam int DB = m3inv_pkg::DetBits;
  logic [NB-1:0] q_r;
  logic [DB:0]   rem_r, d_r, trial;
  logic [5:0]    n_r;
  logic          neg_r, busy_r, done_r;
  logic [NB-1:0] anum;

  assign anum  = num[NB-1] ? NB'(-num) : NB'(num);
  assign trial = {rem_r[DB-1:0], q_r[NB-1]};
  assign busy  = busy_r;
  assign done  = done_r;
  assign quo   = neg_r ? -$signed(q_r) : $signed(q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= anum;
        rem_r  <= '0;
        d_r    <= den[DB-1] ? (DB+1)'(-$signed({den[DB-1], den})) : {1'b0, den};
        neg_r  <= num[NB-1] ^ den[DB-1];
        n_r    <= 6'(NB);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // Shift in one bit, subtract when it fits.
        if (trial >= d_r) begin
          rem_r <= trial - d_r;
          q_r   <= {q_r[NB-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[NB-2:0], 1'b0};
        end
        n_r <= n_r - 6'd1;
        if (n_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ design/m3inv_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Cofactors by one shared multiplier, determinant, then nine divisions (none if singular).
module m3inv_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  input  wire m3inv_pkg::mat_t      q_mat,
  output logic                      q_take,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output logic signed [47:0]        out_inverse_value,
  output logic [3:0]                out_element_index,
  output logic signed [48:0]        out_determinant,
  output logic                      out_singular,
  output logic                      out_last_result
);
  localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_DET = 3'd2,
                         S_DIV = 3'd3, S_WAIT = 3'd4, S_OUT = 3'd5;
  logic [2:0] st_r;
  m3inv_pkg::mat_t m_r;
  m3inv_pkg::cof_t cof_r [9];
  m3inv_pkg::det_t det_r, dacc_r;
  logic [4:0] k_r;
  logic [3:0] idx_r;
  logic signed [m3inv_pkg::ProdBits-1:0] p_r;
  logic signed [m3inv_pkg::ElementBits-1:0] a, b;
  logic [1:0] r1, r2, c1, c2, rr, cc;
  logic [3:0] pos;
  logic dv_start, dv_busy, dv_done;
  logic signed [m3inv_pkg::QBits-1:0] dv_q;
  logic signed [m3inv_pkg::NumBits-1:0] num;
  logic [3:0] tidx;
  logic signed [m3inv_pkg::DetBits-1:0] dprod;

  // Pick operands: step k = 2*pos + half, half 0 is the main diagonal product.
  always_comb begin
    pos = k_r[4:1];
    rr = (pos >= 4'd6) ? 2'd2 : (pos >= 4'd3) ? 2'd1 : 2'd0;
    cc = 2'(pos - 4'(rr) * 4'd3);
    r1 = (rr == 2'd0) ? 2'd1 : 2'd0;
    r2 = (rr == 2'd2) ? 2'd1 : 2'd2;
    c1 = (cc == 2'd0) ? 2'd1 : 2'd0;
    c2 = (cc == 2'd2) ? 2'd1 : 2'd2;
    if (!k_r[0]) begin
      a = m_r.m[4'(r1) * 4'd3 + 4'(c1)];
      b = m_r.m[4'(r2) * 4'd3 + 4'(c2)];
    end else begin
      a = m_r.m[4'(r1) * 4'd3 + 4'(c2)];
      b = m_r.m[4'(r2) * 4'd3 + 4'(c1)];
    end
  end

  // Transposed index for the adjugate element at output position idx.
  always_comb begin
    unique case (idx_r)
      4'd0:    tidx = 4'd0;
      4'd1:    tidx = 4'd3;
      4'd2:    tidx = 4'd6;
      4'd3:    tidx = 4'd1;
      4'd4:    tidx = 4'd4;
      4'd5:    tidx = 4'd7;
      4'd6:    tidx = 4'd2;
      4'd7:    tidx = 4'd5;
      default: tidx = 4'd8;
    endcase
  end

  // Determinant term: first-row element times its cofactor, full width.
  assign dprod = m3inv_pkg::DetBits'($signed(m_r.m[k_r[3:0]])) *
                 m3inv_pkg::DetBits'(cof_r[k_r[3:0]]);

  assign num  = m3inv_pkg::NumBits'(cof_r[tidx]) <<< m3inv_pkg::FractionBits;
  assign dv_start = (st_r == S_DIV) && (det_r != '0);
  assign q_take   = (st_r == S_IDLE) && q_valid;
  assign out_empty = (st_r != S_OUT);

  m3inv_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(num), .den(det_r),
    .busy(dv_busy), .done(dv_done), .quo(dv_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          m_r  <= q_mat;
          k_r  <= 5'd0;
          st_r <= S_MUL;
        end
        S_MUL: begin
          p_r <= a * b;
          // Product is registered in p_r; step k folds the product of step k-1.
          if (k_r != 5'd0) begin
            if (k_r[0]) cof_r[k_r[4:1]] <= m3inv_pkg::CofBits'(p_r);
            else begin
              cof_r[k_r[4:1] - 4'd1] <= ((k_r[4:1] - 4'd1) % 4'd2 == 4'd1) ?
                m3inv_pkg::CofBits'(p_r) - cof_r[k_r[4:1] - 4'd1] :
                cof_r[k_r[4:1] - 4'd1] - m3inv_pkg::CofBits'(p_r);
            end
          end
          if (k_r == 5'd18) begin
            k_r <= 5'd0;
            dacc_r <= '0;
            st_r <= S_DET;
          end else k_r <= k_r + 5'd1;
        end
        S_DET: begin
          dacc_r <= dacc_r + dprod;
          if (k_r == 5'd2) begin
            det_r <= dacc_r + dprod;
            idx_r <= 4'd0;
            st_r  <= S_DIV;
          end else k_r <= k_r + 5'd1;
        end
        S_DIV: begin
          if (det_r == '0) begin
            out_inverse_value <= '0;
            out_element_index <= '0;
            out_determinant   <= '0;
            out_singular      <= 1'b1;
            out_last_result   <= 1'b1;
            st_r <= S_OUT;
          end else st_r <= S_WAIT;
        end
        S_WAIT: if (dv_done) begin
          out_inverse_value <= m3inv_pkg::InvBits'(dv_q);
          out_element_index <= idx_r;
          out_determinant   <= det_r;
          out_singular      <= 1'b0;
          out_last_result   <= (idx_r == 4'd8);
          st_r <= S_OUT;
        end
        S_OUT: if (out_pop) begin
          if (out_last_result) st_r <= S_IDLE;
          else begin
            idx_r <= idx_r + 4'd1;
            st_r  <= S_DIV;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEVER(a_div_idle_start, clk, rst_n, dv_start && dv_busy)
endmodule
`default_nettype wire

@@ design/matrix3_inverse_adjugate_unit.sv @@
// 3x3 inverse by adjugate.
// Input: push one 16-bit element per beat (in_push/in_full), row-major,
// nine beats per matrix. A loader gathers the matrix into a two-entry queue,
// so loading the next matrix overlaps solving the current one.
// Output: a queue face (out_empty/out_pop); nine beats per matrix carrying
// the inverse element (16 fraction bits, truncated toward zero), its index,
// the determinant and last_result on index 8; a singular matrix gives one
// beat with singular set.
// Sequence: the idle state takes a matrix, then the cofactor products run on
// one multiplier, then the determinant; per element the solver starts the
// 49-step bit-serial divider, waits for it and presents the beat.
// The divider sets the rate. Stalling pop holds the current beat and the
// solver; the loader keeps taking elements until its queue is full. Reset
// empties both sides.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module matrix3_inverse_adjugate_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic signed [15:0] in_element_value,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic signed [47:0]      out_inverse_value,
  output logic [3:0]              out_element_index,
  output logic signed [48:0]      out_determinant,
  output logic                    out_singular,
  output logic                    out_last_result
);
  logic q_valid, q_take;
  m3inv_pkg::mat_t q_mat;

  m3inv_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_element_value(in_element_value), .q_valid(q_valid), .q_mat(q_mat),
    .q_take(q_take)
  );

  m3inv_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_mat(q_mat), .q_take(q_take),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_inverse_value(out_inverse_value), .out_element_index(out_element_index),
    .out_determinant(out_determinant), .out_singular(out_singular),
    .out_last_result(out_last_result)
  );

  `ASSERT_NEVER(a_take_needs_valid, clk, rst_n, q_take && !q_valid)
  `ASSERT_CLK(a_sing_last, clk, rst_n, (!out_empty && out_singular) |-> out_last_result)
  `ASSERT_CLK(a_last_idx, clk, rst_n,
    (!out_empty && !out_singular) |-> (out_last_result == (out_element_index == 4'd8)))
endmodule
`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;
  localparam int LimitCycles = 1000000;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic signed [15:0] in_element_value;
  logic               out_empty;
  logic               out_pop;
  logic signed [47:0] out_inverse_value;
  logic [3:0]         out_element_index;
  logic signed [48:0] out_determinant;
  logic               out_singular;
  logic               out_last_result;

  typedef struct {
    logic signed [47:0] inverse_value;
    logic [3:0]         element_index;
    logic signed [48:0] determinant;
    logic               singular;
    logic               last_result;
  } inverse_beat_t;

  inverse_beat_t pending_inverse[$];
  longint        matrix_cells[9];
  int            cells_loaded;
  int            error_count;
  int            pop_hold_cycles;
  bit            pop_steady;
  longint        cycle_count;

  matrix3_inverse_adjugate_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_element_value  (in_element_value),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_inverse_value (out_inverse_value),
    .out_element_index (out_element_index),
    .out_determinant   (out_determinant),
    .out_singular      (out_singular),
    .out_last_result   (out_last_result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Signed cofactor of (r,c) from the loaded cells.
  function automatic longint cofactor_of(int r, int c);
    int     r1;
    int     r2;
    int     c1;
    int     c2;
    longint minor;
    r1 = (r == 0) ? 1 : 0;
    r2 = (r == 2) ? 1 : 2;
    c1 = (c == 0) ? 1 : 0;
    c2 = (c == 2) ? 1 : 2;
    minor = matrix_cells[r1*3+c1] * matrix_cells[r2*3+c2]
          - matrix_cells[r1*3+c2] * matrix_cells[r2*3+c1];
    return ((r + c) % 2 == 1) ? -minor : minor;
  endfunction

  // Load one element; on the ninth, queue the inverse beats.
  task automatic load_matrix_cell(input logic signed [15:0] value);
    longint        cof[3][3];
    longint        det;
    longint        quot;
    inverse_beat_t beat;
    matrix_cells[cells_loaded] = value;
    cells_loaded++;
    if (cells_loaded < 9) return;
    cells_loaded = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        cof[i][j] = cofactor_of(i, j);
    det = matrix_cells[0]*cof[0][0] + matrix_cells[1]*cof[0][1]
        + matrix_cells[2]*cof[0][2];
    if (det == 0) begin
      beat.inverse_value = '0;
      beat.element_index = '0;
      beat.determinant   = '0;
      beat.singular      = 1'b1;
      beat.last_result   = 1'b1;
      pending_inverse.push_back(beat);
      return;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        quot = (cof[j][i] * (64'sd1 <<< m3inv_pkg::FractionBits)) / det;
        if (quot > 64'sh00007FFFFFFFFFFF) quot = 64'sh00007FFFFFFFFFFF;
        if (quot < -64'sh0000800000000000) quot = -64'sh0000800000000000;
        beat.inverse_value = quot[47:0];
        beat.element_index = 4'(i*3 + j);
        beat.determinant   = det[48:0];
        beat.singular      = 1'b0;
        beat.last_result   = (i == 2 && j == 2);
        pending_inverse.push_back(beat);
      end
    end
  endtask

  // Offer one element after a gap; return at the falling edge after its beat.
  task automatic push_element(input logic signed [15:0] value, input int gap);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push          <= 1'b1;
    in_element_value <= value;
    do @(posedge clk); while (in_full);
    load_matrix_cell(value);
    @(negedge clk);
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic push_matrix(input logic signed [15:0] cells[9], input bit no_gaps);
    for (int k = 0; k < 9; k++)
      push_element(cells[k], no_gaps ? 0 : pick_gap());
  endtask

  task automatic test_identity();
    logic signed [15:0] m[9];
    m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
    push_matrix(m, 1'b1);
  endtask

  task automatic test_extremes();
    logic signed [15:0] m[9];
    m = '{-32768, 32767, 0, 0, -32768, 32767, 32767, 0, -32768};
    push_matrix(m, 1'b0);
  endtask

  task automatic test_singular_zero();
    logic signed [15:0] m[9];
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    push_matrix(m, 1'b0);
  endtask

  // Mix of full-range, small, singular and extreme matrices.
  task automatic test_random_matrices(input int count);
    logic signed [15:0] m[9];
    int                 kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 9);
      pop_steady = (n % 10 == 5);
      for (int k = 0; k < 9; k++) begin
        case (kind)
          0, 1, 2, 3: m[k] = 16'($urandom);
          4, 5:       m[k] = 16'($signed($urandom_range(0, 16)) - 8);
          6:          m[k] = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
          default:    m[k] = 16'($signed($urandom_range(0, 512)) - 256);
        endcase
      end
      // Force a dependent row on some matrices.
      if (kind == 7 || kind == 8) begin
        m[6] = m[0];
        m[7] = m[1];
        m[8] = m[2];
      end
      push_matrix(m, pop_steady);
    end
    pop_steady = 1'b0;
  endtask

  // Hold off the receiver while elements keep coming, so input stalls.
  task automatic test_backpressure();
    logic signed [15:0] m[9];
    pop_hold_cycles = 1500;
    for (int n = 0; n < 5; n++) begin
      for (int k = 0; k < 9; k++) m[k] = 16'($urandom);
      push_matrix(m, 1'b1);
    end
  endtask

  // Drive the receiver: random stalls, long hold-off or steady pop on request.
  initial begin
    int stall_left;
    out_pop    = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (pop_hold_cycles > 0) begin
        pop_hold_cycles--;
        out_pop <= 1'b0;
      end else if (pop_steady) begin
        out_pop <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else begin
        if ($urandom_range(0, 99) < 4) stall_left = $urandom_range(10, 80);
        else if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
        out_pop <= 1'b1;
      end
    end
  end

  // Compare each popped beat with the oldest expectation.
  always @(posedge clk) begin
    inverse_beat_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_inverse.size() == 0) begin
        $display("%0t: unexpected beat inverse=%0d index=%0d", $time,
                 out_inverse_value, out_element_index);
        error_count++;
      end else begin
        want = pending_inverse.pop_front();
        if (out_inverse_value !== want.inverse_value) begin
          $display("%0t: inverse_value expected %0d actual %0d", $time,
                   want.inverse_value, out_inverse_value);
          error_count++;
        end
        if (out_element_index !== want.element_index) begin
          $display("%0t: element_index expected %0d actual %0d", $time,
                   want.element_index, out_element_index);
          error_count++;
        end
        if (out_determinant !== want.determinant) begin
          $display("%0t: determinant expected %0d actual %0d", $time,
                   want.determinant, out_determinant);
          error_count++;
        end
        if (out_singular !== want.singular) begin
          $display("%0t: singular expected %0b actual %0b", $time,
                   want.singular, out_singular);
          error_count++;
        end
        if (out_last_result !== want.last_result) begin
          $display("%0t: last_result expected %0b actual %0b", $time,
                   want.last_result, out_last_result);
          error_count++;
        end
      end
    end
  end

  // Bound the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LimitCycles) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_push          = 1'b0;
    in_element_value = '0;
    cells_loaded     = 0;
    error_count      = 0;
    pop_hold_cycles  = 0;
    pop_steady       = 1'b0;
    cycle_count      = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_identity();
    test_extremes();
    test_singular_zero();
    test_backpressure();
    test_random_matrices(33);

    in_push <= 1'b0;
    while (pending_inverse.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
